/* rtl/date_text_validator_top_defines.svh */
// Assertion macros shared by the checker files of the date text validator.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef DATE_TEXT_VALIDATOR_TOP_DEFINES_SVH
`define DATE_TEXT_VALIDATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("date text validator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("date text validator assertion failed");

`endif

/* rtl/dtv_pkg.sv */
// Package of the date text validator: status codes, character codes and calendar helpers.
// Used by dtv_judge, date_text_validator_top and dtv_checker; depends on nothing.
`default_nettype none

package dtv_pkg;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_CHAR  = 3'd1,
      ST_EXTRA_SEP = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_MONTH     = 3'd4,
      ST_YEAR      = 3'd5,
      ST_DAY       = 3'd6
   } dtv_status_type;

   typedef struct packed {
      logic [2:0]     digit_seen;
      dtv_status_type sticky;
      logic [8:0]     year_rem;
   } dtv_flags_type;

   localparam int         OUT_WIDTH      = 14;
   localparam logic [13:0] OUT_MAX        = 14'h3FFF;
   localparam logic [13:0] YEAR_FLOOR_RST = 14'd2000;
   localparam logic [13:0] YEAR_CEIL_RST  = 14'd2100;
   localparam logic        CSR_YEAR_FLOOR = 1'b0;
   localparam logic        CSR_YEAR_CEIL  = 1'b1;
   localparam logic [7:0]  CH_SLASH       = 8'h2F;
   localparam logic [7:0]  CH_DASH        = 8'h2D;
   localparam logic [7:0]  CH_ZERO        = 8'h30;
   localparam logic [7:0]  CH_NINE        = 8'h39;
   localparam logic [3:0]  MONTHS         = 4'd12;
   localparam logic [1:0]  LAST_PART      = 2'd2;

   // Year modulo 400 after appending one decimal digit.
   function automatic logic [8:0] next_rem(input logic [8:0] rem, input logic [3:0] digit);
      logic [11:0] v;
      logic [17:0] p;
      logic [3:0]  q;
      logic [12:0] t;
      v = {rem, 3'b000} + {2'b00, rem, 1'b0} + {8'b0, digit};
      p = 18'(v) * 18'd41;
      q = p[17:14];
      t = 13'(v) - 13'(13'(q) * 13'd400);
      if (t[12]) begin
         t = t + 13'd400;
      end
      return t[8:0];
   endfunction

   function automatic logic is_leap_rem(input logic [8:0] rem);
      return (rem[1:0] == 2'b00) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2: begin
            days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = 5'd30;
         end
         default: begin
            days = 5'd31;
         end
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

/* rtl/date_text_validator_top.sv */
// Top level of the date text validator: request register, parse state and response register.
// Depends on dtv_pkg and dtv_judge.
//
// A date text arrives one character per request on the req_ channel; req_tuser low with
// req_tlast high is a bare end marker. The request with req_tlast high yields exactly one
// response on the rsp_ channel with the verdict and the parsed day, month and year.
// Other requests yield no response.
// One request is accepted per cycle while req_tready is high. After its last request is
// accepted, a text waits in the request register while the parse state is updated, then
// in the verdict stage that feeds the response register.
// When the receiver holds rsp_tready low, the response register holds its data. Requests
// without req_tlast keep flowing into the parse state, the verdict stage takes one more
// finished text, and req_tready falls once a further last request waits in the request
// register. Reset clears the parse state and all valid flags and sets the year bounds to
// 2000 and 2100. The bounds are written through the csr_ port; the user must do so only
// while no text is in flight, as the block does not enforce it.
`default_nettype none

module date_text_validator_top #(
   parameter int ACC_WIDTH = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tuser,   // [0] present
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [2:0] status, [16:3] day_value,
                                         // [30:17] month_value, [44:31] year_value, rest zero
   output logic             rsp_tuser,   // [0] valid_res
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [13:0] csr_wdata
);

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

   function automatic logic [ACC_WIDTH-1:0] push_digit(input logic [ACC_WIDTH-1:0] acc,
                                                       input logic [3:0] digit);
      logic [ACC_WIDTH+3:0] v;
      v = (ACC_WIDTH+4)'({acc, 3'b000}) + (ACC_WIDTH+4)'({acc, 1'b0})
          + (ACC_WIDTH+4)'(digit);
      return (v > (ACC_WIDTH+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [13:0] shown(input logic [ACC_WIDTH-1:0] value);
      return (value > ACC_WIDTH'(dtv_pkg::OUT_MAX)) ? dtv_pkg::OUT_MAX : value[13:0];
   endfunction

   logic [13:0] year_floor_ff, year_floor_in;
   logic [13:0] year_ceil_ff, year_ceil_in;

   logic       a_valid_ff, a_valid_in;
   logic       a_present_ff;
   logic [7:0] a_ch_ff;
   logic       a_last_ff;

   logic [1:0]              part_ff, part_in;
   logic [ACC_WIDTH-1:0]    day_ff, day_in;
   logic [ACC_WIDTH-1:0]    month_ff, month_in;
   logic [ACC_WIDTH-1:0]    year_ff, year_in;
   dtv_pkg::dtv_flags_type  flags_ff, flags_in;

   logic                    b_valid_ff, b_valid_in;
   logic [ACC_WIDTH-1:0]    b_day_ff, b_month_ff, b_year_ff;
   dtv_pkg::dtv_flags_type  b_flags_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff;
   dtv_pkg::dtv_status_type rsp_status_ff;
   logic [13:0]             rsp_day_ff, rsp_month_ff, rsp_year_ff;

   logic                    out_ready;
   logic                    b_ready;
   logic                    a_go;
   logic                    req_fire;
   logic                    capture;
   dtv_pkg::dtv_status_type status;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign b_ready    = !b_valid_ff || out_ready;
   assign a_go       = a_valid_ff && (!a_last_ff || b_ready);
   assign req_tready = !a_valid_ff || a_go;
   assign req_fire   = req_tvalid && req_tready;
   assign capture    = a_go && a_last_ff;

   always_comb begin
      year_floor_in = year_floor_ff;
      year_ceil_in  = year_ceil_ff;
      if (csr_we) begin
         case (csr_index)
            dtv_pkg::CSR_YEAR_FLOOR: begin
               year_floor_in = csr_wdata;
            end
            dtv_pkg::CSR_YEAR_CEIL: begin
               year_ceil_in = csr_wdata;
            end
            default: begin
               year_floor_in = year_floor_ff;
            end
         endcase
      end
   end

   // Parse state after the character in the request register.
   always_comb begin
      part_in  = part_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      flags_in = flags_ff;
      if (a_present_ff && (flags_ff.sticky == dtv_pkg::ST_OK)) begin
         if ((a_ch_ff == dtv_pkg::CH_SLASH) || (a_ch_ff == dtv_pkg::CH_DASH)) begin
            if (part_ff >= dtv_pkg::LAST_PART) begin
               flags_in.sticky = dtv_pkg::ST_EXTRA_SEP;
            end else begin
               part_in = part_ff + 2'd1;
            end
         end else if (a_ch_ff inside {[dtv_pkg::CH_ZERO:dtv_pkg::CH_NINE]}) begin
            case (part_ff)
               2'd0: begin
                  day_in = push_digit(day_ff, a_ch_ff[3:0]);
                  flags_in.digit_seen[0] = 1'b1;
               end
               2'd1: begin
                  month_in = push_digit(month_ff, a_ch_ff[3:0]);
                  flags_in.digit_seen[1] = 1'b1;
               end
               default: begin
                  year_in = push_digit(year_ff, a_ch_ff[3:0]);
                  flags_in.year_rem = dtv_pkg::next_rem(flags_ff.year_rem, a_ch_ff[3:0]);
                  flags_in.digit_seen[2] = 1'b1;
               end
            endcase
         end else begin
            flags_in.sticky = dtv_pkg::ST_BAD_CHAR;
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (b_ready) begin
         b_valid_in = capture;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_floor_ff <= dtv_pkg::YEAR_FLOOR_RST;
         year_ceil_ff  <= dtv_pkg::YEAR_CEIL_RST;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         part_ff       <= '0;
         day_ff        <= '0;
         month_ff      <= '0;
         year_ff       <= '0;
         flags_ff      <= '0;
      end else begin
         year_floor_ff <= year_floor_in;
         year_ceil_ff  <= year_ceil_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (a_go) begin
            if (a_last_ff) begin
               part_ff  <= '0;
               day_ff   <= '0;
               month_ff <= '0;
               year_ff  <= '0;
               flags_ff <= '0;
            end else begin
               part_ff  <= part_in;
               day_ff   <= day_in;
               month_ff <= month_in;
               year_ff  <= year_in;
               flags_ff <= flags_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_present_ff <= req_tuser;
         a_ch_ff      <= req_tdata;
         a_last_ff    <= req_tlast;
      end
      if (capture) begin
         b_day_ff   <= day_in;
         b_month_ff <= month_in;
         b_year_ff  <= year_in;
         b_flags_ff <= flags_in;
      end
      if (b_valid_ff && out_ready) begin
         rsp_ok_ff     <= (status == dtv_pkg::ST_OK);
         rsp_status_ff <= status;
         rsp_day_ff    <= shown(b_day_ff);
         rsp_month_ff  <= shown(b_month_ff);
         rsp_year_ff   <= shown(b_year_ff);
      end
   end

   dtv_judge #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_judge (
      .day          (b_day_ff),
      .month        (b_month_ff),
      .year         (b_year_ff),
      .flags        (b_flags_ff),
      .year_floor   (year_floor_ff),
      .year_ceiling (year_ceil_ff),
      .status       (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_year_ff, rsp_month_ff, rsp_day_ff, rsp_status_ff};

endmodule

`default_nettype wire

/* rtl/dtv_judge.sv */
// Verdict logic of the date text validator: turns the parsed parts into a status code.
// Depends on dtv_pkg for the status codes and the calendar helpers.
`default_nettype none

module dtv_judge #(
   parameter int ACC_WIDTH = 14
) (
   input  wire logic [ACC_WIDTH-1:0] day,
   input  wire logic [ACC_WIDTH-1:0] month,
   input  wire logic [ACC_WIDTH-1:0] year,
   input  wire dtv_pkg::dtv_flags_type flags,
   input  wire logic [13:0]          year_floor,
   input  wire logic [13:0]          year_ceiling,
   output dtv_pkg::dtv_status_type   status
);

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

   logic       leap;
   logic [4:0] dim;

   assign leap = (year != ACC_MAX) && dtv_pkg::is_leap_rem(flags.year_rem);
   assign dim  = dtv_pkg::month_days(month[3:0], leap);

   always_comb begin
      if (flags.sticky != dtv_pkg::ST_OK) begin
         status = flags.sticky;
      end else if (flags.digit_seen != 3'b111) begin
         status = dtv_pkg::ST_EMPTY;
      end else if ((month == '0) || (month > ACC_WIDTH'(dtv_pkg::MONTHS))) begin
         status = dtv_pkg::ST_MONTH;
      end else if ((year < ACC_WIDTH'(year_floor)) || (year > ACC_WIDTH'(year_ceiling))) begin
         status = dtv_pkg::ST_YEAR;
      end else if ((day == '0) || (day > ACC_WIDTH'(dim))) begin
         status = dtv_pkg::ST_DAY;
      end else begin
         status = dtv_pkg::ST_OK;
      end
   end

endmodule

`default_nettype wire

/* rtl/dtv_checker.sv */
// Port-level checker of the date text validator and its bind to the top level.
// Depends on date_text_validator_top_defines.svh for the assertion macros and on dtv_pkg.
`default_nettype none
`include "date_text_validator_top_defines.svh"

module dtv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   logic [2:0]  rsp_status;
   logic [13:0] rsp_day;
   logic [13:0] rsp_month;
   logic [48:0] rsp_word;
   logic        status_ok;
   logic        date_sane;
   logic        rsp_waiting;

   assign rsp_status  = rsp_tdata[2:0];
   assign rsp_day     = rsp_tdata[16:3];
   assign rsp_month   = rsp_tdata[30:17];
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign status_ok   = (rsp_status == dtv_pkg::ST_OK);
   assign date_sane   = (rsp_day != '0) && (rsp_month != '0)
                        && (rsp_month <= 14'(dtv_pkg::MONTHS));
   assign rsp_waiting = rsp_tvalid && !rsp_tready;

   `DTV_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `DTV_ASSERT_NOW(a_verdict_matches_status, clock, reset, rsp_tvalid, rsp_tuser == status_ok)
   `DTV_ASSERT_NOW(a_accepted_date_sane, clock, reset, rsp_tvalid && rsp_tuser, date_sane)
   `DTV_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_waiting, rsp_tvalid && $stable(rsp_word))

endmodule

bind date_text_validator_top dtv_checker u_dtv_checker (.*);

`default_nettype wire
